// ===== rtl/gbp_pkg.sv =====
package gbp_pkg;

	// One color channel, unsigned Q8.8.
	typedef logic [15:0] chan_t;

	// A packed pixel: index 0 red, 1 green, 2 blue.
	typedef chan_t [2:0] px_t;

	// Filter geometry: radius four, nine taps, five output lanes.
	localparam int TAP_RADIUS = 4;
	localparam int NUM_TAPS   = 2 * TAP_RADIUS + 1;
	localparam int NUM_LANES  = TAP_RADIUS + 1;
	localparam int ROW_W      = 12;
	localparam int NUM_BANKS  = 8;
	localparam int BANK_W     = 3;

	// Window of pixels at distances 0 to 8 back along the pass direction.
	typedef px_t [NUM_TAPS-1:0] win_t;

	// Results of all lanes for one input beat.
	typedef px_t [NUM_LANES-1:0] lanes_t;

	// Q0.16 weights, center first, then distances 1 to 4.
	localparam logic [13:0] TAP_W [NUM_LANES] = '{
		14'd14879, 14'd12753, 14'd7971, 14'd3542, 14'd1063
	};

	// Configuration register indexes.
	localparam logic [1:0] CFG_DIRECTION = 2'd0;
	localparam logic [1:0] CFG_WIDTH     = 2'd1;
	localparam logic [1:0] CFG_HEIGHT    = 2'd2;

	// Control that travels with one beat through the pipeline.
	typedef struct packed {
		logic [NUM_LANES-1:0] mask;
		logic                 frame;
	} beat_ctl_t;

endpackage

// ===== rtl/gbp_lane.sv =====
module gbp_lane
	import gbp_pkg::*;
#(
	parameter int LANE = 0
) (
	input  logic       clk,
	input  logic       ld2,
	input  logic       ld3,
	input  win_t       win,
	input  logic [3:0] psat,
	output px_t        res
);

	px_t         s [NUM_TAPS];
	logic [30:0] prod_s2 [3][NUM_LANES];
	logic [33:0] acc [3];
	logic [33:0] rnd [3];
	px_t         sat;

	// Pick the nine samples; positions before the row or column start
	// repeat the edge pixel, positions at or after the current one use it.
	for (genvar i = 0; i < NUM_TAPS; i++) begin : g_tap
		localparam int D = LANE + TAP_RADIUS - i;
		if (D <= 0) begin : g_cur
			assign s[i] = win[0];
		end else begin : g_past
			assign s[i] = (int'(psat) >= D) ? win[D] : win[psat];
		end
	end

	// Symmetric pairs are added first, then weighted.
	always_ff @(posedge clk) begin
		if (ld2) begin
			for (int c = 0; c < 3; c++) begin
				prod_s2[c][0] <= 31'(TAP_W[0]) * 31'(s[TAP_RADIUS][c]);
				for (int t = 1; t < NUM_LANES; t++) begin
					prod_s2[c][t] <= 31'(TAP_W[t]) *
						(31'(s[TAP_RADIUS-t][c]) + 31'(s[TAP_RADIUS+t][c]));
				end
			end
		end
	end

	// Sum, round to nearest and saturate each channel.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc[c] = 34'(prod_s2[c][0]) + 34'(prod_s2[c][1]) + 34'(prod_s2[c][2])
				+ 34'(prod_s2[c][3]) + 34'(prod_s2[c][4]);
			rnd[c] = acc[c] + 34'd32768;
			sat[c] = (rnd[c][33:32] != 2'b00) ? 16'hFFFF : rnd[c][31:16];
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			res <= sat;
		end
	end

endmodule

// ===== rtl/gbp_merge.sv =====
module gbp_merge
	import gbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  beat_ctl_t ctl,
	input  lanes_t    res,
	output logic      free,
	output logic      out_valid,
	input  logic      out_ready,
	output chan_t     red_out,
	output chan_t     green_out,
	output chan_t     blue_out,
	output logic      last_of_run,
	output logic      frame_done
);

	lanes_t               res_q;
	logic [NUM_LANES-1:0] pend_q;
	logic                 frame_q;
	logic [2:0]           sel;
	logic                 single;
	logic                 out_fire;

	// The oldest pending result is the highest lane still set.
	always_comb begin
		sel = '0;
		for (int j = 0; j < NUM_LANES; j++) begin
			if (pend_q[j]) begin
				sel = 3'(j);
			end
		end
	end

	assign single    = (pend_q != '0) && ((pend_q & (pend_q - 1'b1)) == '0);
	assign out_valid = (pend_q != '0);
	assign out_fire  = out_valid && out_ready;
	assign free      = (pend_q == '0) || (out_ready && single);

	assign red_out     = res_q[sel][0];
	assign green_out   = res_q[sel][1];
	assign blue_out    = res_q[sel][2];
	assign last_of_run = single;
	assign frame_done  = single && frame_q;

	// Pending mask: loaded with a new run, one bit cleared per beat sent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= ctl.mask;
		end else if (out_fire) begin
			pend_q <= pend_q & ~(NUM_LANES'(1) << sel);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q   <= res;
			frame_q <= ctl.frame;
		end
	end

endmodule

// ===== rtl/separable_gaussian_blur_pass.sv =====
// Channel  | Direction | Handshake               | Payload
// in       | input     | in_valid / in_ready     | red, green, blue
// out      | output    | out_valid / out_ready   | red_out, green_out, blue_out,
//          |           |                         | last_of_run, frame_done
// cfg      | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One pixel is taken per clock while in_ready is high. A run end yields up to
// five results, sent one per clock while out_ready is high by the single
// output port; while a run drains, later beats queue in the three stages
// behind it, and in_ready drops only once all are full. Reset clears counters
// and valids; line banks are not cleared. A stall on the output backs up
// through three pipeline stages to in_ready.
module separable_gaussian_blur_pass
	import gbp_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  chan_t       red,
	input  chan_t       green,
	input  chan_t       blue,
	output logic        out_valid,
	input  logic        out_ready,
	output chan_t       red_out,
	output chan_t       green_out,
	output chan_t       blue_out,
	output logic        last_of_run,
	output logic        frame_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic             dir_q;
	logic [10:0]      width_q;
	logic [12:0]      height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] wm1;
	logic [ROW_W-1:0] hm1;
	logic [COL_W-1:0] x;
	logic [ROW_W-1:0] r;
	logic             lastc;
	logic             lastr;
	logic             last;
	logic [3:0]       psat;
	beat_ctl_t        ctl_in;
	px_t              cur;
	logic             in_fire;
	px_t              sh_q [8];

	logic             v1_q;
	logic             v2_q;
	logic             v3_q;
	logic             ld1;
	logic             ld2;
	logic             ld3;
	logic             m_free;
	logic             m_load;
	px_t              cur_s1;
	px_t              hwin_s1 [1:8];
	px_t              rd_s1 [NUM_BANKS];
	logic [2:0]       rlo_s1;
	logic             vert_s1;
	logic [3:0]       psat_s1;
	beat_ctl_t        ctl_s1;
	beat_ctl_t        ctl_s2;
	beat_ctl_t        ctl_s3;
	win_t             win;
	lanes_t           res_s3;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= 1'b0;
			width_q  <= 11'd640;
			height_q <= 13'd480;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DIRECTION: dir_q    <= cfg_data[0];
				CFG_WIDTH:     width_q  <= cfg_data[10:0];
				CFG_HEIGHT:    height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Last column and row indexes after clamping the frame size.
	always_comb begin
		if (width_q == '0) begin
			wm1 = '0;
		end else if (int'(width_q) > MAX_WIDTH) begin
			wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = COL_W'(width_q - 11'd1);
		end
		if (height_q == '0) begin
			hm1 = '0;
		end else if (height_q > 13'd4096) begin
			hm1 = '1;
		end else begin
			hm1 = ROW_W'(height_q - 13'd1);
		end
	end

	// Position of the incoming pixel and which lanes produce a result.
	always_comb begin
		x     = (col_q > wm1) ? wm1 : col_q;
		r     = (row_q > hm1) ? hm1 : row_q;
		lastc = (x == wm1);
		lastr = (r == hm1);
		last  = dir_q ? lastr : lastc;
		if (dir_q) begin
			psat = (int'(r) >= 8) ? 4'd8 : 4'(r);
		end else begin
			psat = (int'(x) >= 8) ? 4'd8 : 4'(x);
		end
		for (int j = 0; j < NUM_LANES; j++) begin
			ctl_in.mask[j] = (int'(psat) >= j) && (last || (j == TAP_RADIUS));
		end
		ctl_in.frame = lastc && lastr;
	end

	assign cur     = '{blue, green, red};
	assign in_fire = in_valid && in_ready;

	// Stall chain: a stage loads when it is empty or its successor moves.
	assign ld3      = !v3_q || (ctl_s3.mask == '0) || m_free;
	assign ld2      = !v2_q || ld3;
	assign ld1      = !v1_q || ld2;
	assign in_ready = ld1;
	assign m_load   = v3_q && (ctl_s3.mask != '0) && m_free;

	// Raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (lastc) begin
				col_q <= '0;
				row_q <= lastr ? '0 : r + 1'b1;
			end else begin
				col_q <= x + 1'b1;
				row_q <= r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (ld1) v1_q <= in_fire;
			if (ld2) v2_q <= v1_q;
			if (ld3) v3_q <= v2_q;
		end
	end

	// Row window indexed by column modulo eight, and stage one capture.
	// The window is read before the current pixel lands in it.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sh_q[x[2:0]] <= cur;
			cur_s1 <= cur;
			for (int k = 1; k <= 8; k++) begin
				hwin_s1[k] <= sh_q[3'(x[2:0] - 3'(k))];
			end
			rlo_s1  <= r[2:0];
			vert_s1 <= dir_q;
			psat_s1 <= psat;
			ctl_s1  <= ctl_in;
		end
		if (ld2) ctl_s2 <= ctl_s1;
		if (ld3) ctl_s3 <= ctl_s2;
	end

	// Line banks, one per row modulo eight, read before write at column x.
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		px_t mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (in_fire) begin
				rd_s1[b] <= mem[x];
				if (r[2:0] == BANK_W'(b)) begin
					mem[x] <= cur;
				end
			end
		end
	end

	// Window by distance: rows above for vertical, pixels to the left else.
	always_comb begin
		win[0] = cur_s1;
		for (int d = 1; d <= 8; d++) begin
			win[d] = vert_s1 ? rd_s1[3'(rlo_s1 - 3'(d))] : hwin_s1[d];
		end
	end

	for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
		gbp_lane #(
			.LANE(j)
		) u_lane (
			.clk  (clk),
			.ld2  (ld2),
			.ld3  (ld3),
			.win  (win),
			.psat (psat_s1),
			.res  (res_s3[j])
		);
	end

	gbp_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (m_load),
		.ctl         (ctl_s3),
		.res         (res_s3),
		.free        (m_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

endmodule

// ===== rtl/gbp_checker.sv =====
module gbp_checker
	import gbp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input chan_t       red_out,
	input chan_t       green_out,
	input chan_t       blue_out,
	input logic        last_of_run,
	input logic        frame_done,
	input logic        cfg_ready
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out)
			&& $stable(green_out) && $stable(blue_out) && $stable(last_of_run))
		else $error("output beat changed while stalled");

	// The frame's last result also closes its run.
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_of_run)
		else $error("frame_done without last_of_run");

	// Input is only held off when a result is waiting.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// Configuration writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind separable_gaussian_blur_pass gbp_checker u_chk (.*);
